// ----- sv/dipmc_pkg.sv -----
// Shared types and constants for the dual incremental PID motor controller.
// No dependencies; imported by every module of the block.
package dipmc_pkg;

   localparam int GAIN_W   = 16;
   localparam int PERIOD_W = 10;
   localparam int LIMIT_W  = 7;
   localparam int ENC_W    = 16;
   localparam int ERR_W    = 17;
   localparam int DRIVE_W  = 20;
   localparam int Q_SHIFT  = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [PERIOD_W-1:0] RESET_TICK_PERIOD = PERIOD_W'(10);
   localparam logic [LIMIT_W-1:0]  RESET_DRIVE_LIMIT = LIMIT_W'(100);

   localparam logic MODE_SPEED  = 1'b0;
   localparam logic MODE_FOLLOW = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPEED_KP    = 3'd0,
      CSR_SPEED_KI    = 3'd1,
      CSR_SPEED_KD    = 3'd2,
      CSR_FOLLOW_KP   = 3'd3,
      CSR_FOLLOW_KI   = 3'd4,
      CSR_FOLLOW_KD   = 3'd5,
      CSR_TICK_PERIOD = 3'd6,
      CSR_DRIVE_LIMIT = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0] kp;
      logic [GAIN_W-1:0] ki;
      logic [GAIN_W-1:0] kd;
   } pid_gains_type;

   typedef struct packed {
      pid_gains_type        speed;
      pid_gains_type        follow;
      logic [PERIOD_W-1:0]  tick_period;
      logic [LIMIT_W-1:0]   drive_limit;
   } ctrl_cfg_type;

endpackage

// ----- sv/dual_incremental_pid_motor_control_top.sv -----
// Dual incremental PID motor controller, top level. Depends on dipmc_pkg,
// dipmc_csr and dipmc_pid_loop.
//
// Each item on the req_ channel is one timer tick carrying the mode, the
// speed target and both encoder deltas; each tick yields exactly one item on
// the rsp_ channel. A tick counter fires a control step every tick_period
// ticks (a period of 0 or 1 steps on every tick). In speed mode the speed
// loop drives motor one from speed_target - enc1_delta; in follow mode both
// deltas are summed into 16-bit wrapping positions and the follow loop drives
// motor two from leader minus follower. Drives are signed Q12, clamped to
// +/- drive_limit whole units; gains are unsigned Q4.12. Throughput is one
// tick per clock while rsp_stall is low; a tick is captured in the input
// register, then applied to the controller state, which is itself the result
// register. The clock is bounded by the gain multiply, accumulate and clamp
// path inside each loop. Configuration writes are always ready and must be
// issued only while the block is idle.
module dual_incremental_pid_motor_control_top
   import dipmc_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_mode,
   input  logic signed [ENC_W-1:0]     req_speed_target,
   input  logic signed [ENC_W-1:0]     req_enc1_delta,
   input  logic signed [ENC_W-1:0]     req_enc2_delta,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_updated,
   output logic signed [DRIVE_W-1:0]   rsp_motor1_drive,
   output logic signed [DRIVE_W-1:0]   rsp_motor2_drive,
   output logic signed [ENC_W-1:0]     rsp_measured_speed,
   output logic signed [ENC_W-1:0]     rsp_leader_position,
   output logic signed [ENC_W-1:0]     rsp_follower_position,

   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata
);

   ctrl_cfg_type cfg;

   // Input register
   logic                    in_valid_ff, in_valid_in;
   logic                    in_mode_ff;
   logic signed [ENC_W-1:0] in_target_ff, in_enc1_ff, in_enc2_ff;

   // Result side: valid and step flag; the rest reads straight from state
   logic rsp_valid_ff, rsp_valid_in;
   logic updated_ff;

   // Controller state
   logic [PERIOD_W-1:0]     tick_count_ff, tick_count_in, tick_next;
   logic signed [ENC_W-1:0] speed_seen_ff, leader_ff, follower_ff;
   logic signed [ENC_W-1:0] leader_in, follower_in;

   logic                    req_take, advance, fire;
   logic                    speed_step, follow_step;
   logic signed [ERR_W-1:0] speed_err, follow_err;

   assign csr_ready = 1'b1;

   dipmc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // Advance the held tick whenever the result slot is empty or being drained;
   // state and result update together, so a stalled result never sees the
   // state move under it.
   assign advance   = in_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   assign in_valid_in  = req_take | (in_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the payload while waiting; load only on accept.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff   <= req_mode;
         in_target_ff <= req_speed_target;
         in_enc1_ff   <= req_enc1_delta;
         in_enc2_ff   <= req_enc2_delta;
      end
   end

   // Tick counter: clears when it fires, and fires at or above the period so a
   // period lowered below the running count steps on the next tick.
   assign tick_next     = tick_count_ff + PERIOD_W'(1);
   assign fire          = (tick_next >= cfg.tick_period);
   assign tick_count_in = fire ? '0 : tick_next;

   assign speed_step  = advance & fire & (in_mode_ff == MODE_SPEED);
   assign follow_step = advance & fire & (in_mode_ff == MODE_FOLLOW);

   // Speed error and the wrapped positions of the follow loop
   assign speed_err   = ERR_W'(in_target_ff) - ERR_W'(in_enc1_ff);
   assign leader_in   = leader_ff + in_enc1_ff;
   assign follower_in = follower_ff + in_enc2_ff;
   assign follow_err  = ERR_W'(leader_in) - ERR_W'(follower_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
         speed_seen_ff <= '0;
         leader_ff     <= '0;
         follower_ff   <= '0;
         updated_ff    <= 1'b0;
      end else if (advance) begin
         tick_count_ff <= tick_count_in;
         updated_ff    <= fire;
         if (fire) begin
            speed_seen_ff <= in_enc1_ff;
         end
         if (follow_step) begin
            leader_ff   <= leader_in;
            follower_ff <= follower_in;
         end
      end
   end

   dipmc_pid_loop u_speed_loop (
      .clock (clock),
      .reset (reset),
      .step  (speed_step),
      .err   (speed_err),
      .gains (cfg.speed),
      .limit (cfg.drive_limit),
      .acc   (rsp_motor1_drive)
   );

   dipmc_pid_loop u_follow_loop (
      .clock (clock),
      .reset (reset),
      .step  (follow_step),
      .err   (follow_err),
      .gains (cfg.follow),
      .limit (cfg.drive_limit),
      .acc   (rsp_motor2_drive)
   );

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_updated           = updated_ff;
   assign rsp_measured_speed    = speed_seen_ff;
   assign rsp_leader_position   = leader_ff;
   assign rsp_follower_position = follower_ff;

endmodule

// ----- sv/dipmc_csr.sv -----
// Configuration register file: gains, tick period and drive limit.
// Depends on dipmc_pkg.
module dipmc_csr
   import dipmc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [CSR_IDX_W-1:0]  wr_index,
   input  logic [CSR_DATA_W-1:0] wr_data,
   output ctrl_cfg_type          cfg
);

   ctrl_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_index_type'(wr_index))
            CSR_SPEED_KP:    cfg_in.speed.kp    = wr_data;
            CSR_SPEED_KI:    cfg_in.speed.ki    = wr_data;
            CSR_SPEED_KD:    cfg_in.speed.kd    = wr_data;
            CSR_FOLLOW_KP:   cfg_in.follow.kp   = wr_data;
            CSR_FOLLOW_KI:   cfg_in.follow.ki   = wr_data;
            CSR_FOLLOW_KD:   cfg_in.follow.kd   = wr_data;
            CSR_TICK_PERIOD: cfg_in.tick_period = wr_data[PERIOD_W-1:0];
            CSR_DRIVE_LIMIT: cfg_in.drive_limit = wr_data[LIMIT_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed.kp    <= GAIN_W'(2048);
         cfg_ff.speed.ki    <= GAIN_W'(655);
         cfg_ff.speed.kd    <= GAIN_W'(2048);
         cfg_ff.follow.kp   <= GAIN_W'(1638);
         cfg_ff.follow.ki   <= '0;
         cfg_ff.follow.kd   <= '0;
         cfg_ff.tick_period <= RESET_TICK_PERIOD;
         cfg_ff.drive_limit <= RESET_DRIVE_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/dipmc_pid_loop.sv -----
// One incremental PID loop: two-deep error history, Q12 drive accumulator
// and symmetric clamp. Depends on dipmc_pkg.
module dipmc_pid_loop
   import dipmc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic signed [ERR_W-1:0]    err,
   input  pid_gains_type              gains,
   input  logic [LIMIT_W-1:0]         limit,
   output logic signed [DRIVE_W-1:0]  acc
);

   localparam int DP_W  = ERR_W + 1;
   localparam int DD_W  = ERR_W + 2;
   localparam int PP_W  = GAIN_W + 1 + DP_W;
   localparam int PI_W  = GAIN_W + 1 + ERR_W;
   localparam int PD_W  = GAIN_W + 1 + DD_W;
   localparam int SUM_W = PD_W + 2;

   logic signed [ERR_W-1:0]   hist0_ff, hist1_ff;
   logic signed [DRIVE_W-1:0] acc_ff, acc_in;

   logic signed [DP_W-1:0]    diff_p;
   logic signed [DD_W-1:0]    diff_d;
   logic signed [PP_W-1:0]    prod_p;
   logic signed [PI_W-1:0]    prod_i;
   logic signed [PD_W-1:0]    prod_d;
   logic signed [SUM_W-1:0]   sum, lim_pos, lim_neg;

   assign diff_p = DP_W'(err) - DP_W'(hist0_ff);
   assign diff_d = DD_W'(err) - (DD_W'(hist0_ff) <<< 1) + DD_W'(hist1_ff);

   assign prod_p = $signed({1'b0, gains.kp}) * diff_p;
   assign prod_i = $signed({1'b0, gains.ki}) * err;
   assign prod_d = $signed({1'b0, gains.kd}) * diff_d;

   assign sum = SUM_W'(acc_ff) + SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);

   assign lim_pos = $signed({(SUM_W - LIMIT_W - Q_SHIFT)'(0), limit, Q_SHIFT'(0)});
   assign lim_neg = -lim_pos;

   // Saturate once, after the increment lands in the accumulator.
   always_comb begin
      priority if (sum > lim_pos) begin
         acc_in = DRIVE_W'(lim_pos);
      end else if (sum < lim_neg) begin
         acc_in = DRIVE_W'(lim_neg);
      end else begin
         acc_in = DRIVE_W'(sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist0_ff <= '0;
         hist1_ff <= '0;
         acc_ff   <= '0;
      end else if (step) begin
         hist0_ff <= err;
         hist1_ff <= hist0_ff;
         acc_ff   <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule
